### hw/rtl/pcp_pkg.sv
// Package: shared widths, codes, state types and control structs for the playback clock.
`timescale 1ns / 1ps

package pcp_pkg;

  localparam int ELAPSED_BITS  = 32;
  localparam int FRACTION_BITS = 16;
  localparam int DUR_W         = 24;
  localparam int DELTA_W       = 16;
  localparam int OP_W          = 3;
  localparam int MODE_W        = 2;
  localparam int RUN_W         = 2;
  localparam int PROG_W        = 17;
  localparam int CFG_IDX_W     = 1;
  localparam int RES_W         = FRACTION_BITS + 1;
  localparam int CMP_W         = (ELAPSED_BITS > DUR_W) ? ELAPSED_BITS : DUR_W;
  localparam int STEPS         = ELAPSED_BITS + FRACTION_BITS + 1;
  localparam int CNT_W         = $clog2(STEPS + 1);

  localparam logic [DUR_W-1:0] DUR_RESET = DUR_W'(1000);
  localparam logic [RES_W-1:0] ONE_FIX   = {1'b1, {FRACTION_BITS{1'b0}}};

  typedef enum logic [OP_W-1:0] {
    OP_TICK   = 3'd0,
    OP_PLAY   = 3'd1,
    OP_PAUSE  = 3'd2,
    OP_RESUME = 3'd3,
    OP_STOP   = 3'd4,
    OP_RESET  = 3'd5
  } op_t;

  typedef enum logic [MODE_W-1:0] {
    MODE_ONCE   = 2'd0,
    MODE_LOOP   = 2'd1,
    MODE_BOUNCE = 2'd2
  } mode_t;

  typedef enum logic [RUN_W-1:0] {
    RUN_STOPPED = 2'd0,
    RUN_PLAYING = 2'd1,
    RUN_PAUSED  = 2'd2
  } run_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PLAY_MODE = 1'd0,
    REG_DURATION  = 1'd1
  } reg_idx_t;

  typedef enum logic [1:0] {
    FSM_IDLE   = 2'd0,
    FSM_LAUNCH = 2'd1,
    FSM_DIVIDE = 2'd2
  } fsm_t;

  typedef struct packed {
    logic start;
    logic reflect;
  } div_ctrl_t;

  typedef struct packed {
    logic busy;
    logic peak;
  } div_stat_t;

endpackage

### hw/rtl/pcp_if.sv
// Interfaces: command channel and result channel of the playback clock.
`timescale 1ns / 1ps

interface pcp_cmd_if;
  logic                             valid;
  logic                             ready;
  logic [pcp_pkg::OP_W-1:0]         opcode;
  logic [pcp_pkg::DELTA_W-1:0]      time_delta;

  modport source (output valid, output opcode, output time_delta, input ready);
  modport sink   (input valid, input opcode, input time_delta, output ready);
endinterface

interface pcp_res_if;
  logic                             valid;
  logic                             ready;
  logic                             playing;
  logic                             paused;
  logic [pcp_pkg::PROG_W-1:0]       progress;
  logic [pcp_pkg::RUN_W-1:0]        run_status;

  modport source (output valid, output playing, output paused, output progress,
                  output run_status, input ready);
  modport sink   (input valid, input playing, input paused, input progress,
                  input run_status, output ready);
endinterface

### hw/rtl/pcp_divider.sv
// Bit-serial restoring divider: elapsed modulo duration, reflection, then fraction bits.
`timescale 1ns / 1ps

module pcp_divider (
  input  logic                              clk,
  input  logic                              rst_n,
  input  pcp_pkg::div_ctrl_t                ctrl,
  input  logic [pcp_pkg::ELAPSED_BITS-1:0]  dividend,
  input  logic [pcp_pkg::DUR_W-1:0]         divisor,
  output logic [pcp_pkg::FRACTION_BITS-1:0] frac,
  output pcp_pkg::div_stat_t                stat
);

  logic                              busy_r, busy_nxt;
  logic                              peak_r, peak_nxt;
  logic                              reflect_r, reflect_nxt;
  logic [pcp_pkg::CNT_W-1:0]         cnt_r, cnt_nxt;
  logic [pcp_pkg::DUR_W-1:0]         rem_r, rem_nxt;
  logic [pcp_pkg::DUR_W-1:0]         dsr_r, dsr_nxt;
  logic [pcp_pkg::ELAPSED_BITS-1:0]  dvd_r, dvd_nxt;
  logic [pcp_pkg::FRACTION_BITS-1:0] quo_r, quo_nxt;

  logic [pcp_pkg::DUR_W:0]           trial;
  logic [pcp_pkg::DUR_W:0]           diff;
  logic                              fits;
  logic                              fix_step;
  logic                              last_step;

  always_comb begin
    trial     = {rem_r, dvd_r[pcp_pkg::ELAPSED_BITS-1]};
    diff      = trial - {1'b0, dsr_r};
    fits      = (trial >= {1'b0, dsr_r});
    fix_step  = (cnt_r == pcp_pkg::CNT_W'(pcp_pkg::ELAPSED_BITS));
    last_step = (cnt_r == pcp_pkg::CNT_W'(pcp_pkg::STEPS - 1));

    busy_nxt    = busy_r;
    peak_nxt    = peak_r;
    reflect_nxt = reflect_r;
    cnt_nxt     = cnt_r;
    rem_nxt     = rem_r;
    dsr_nxt     = dsr_r;
    dvd_nxt     = dvd_r;
    quo_nxt     = quo_r;

    if (ctrl.start) begin
      busy_nxt    = 1'b1;
      peak_nxt    = 1'b0;
      reflect_nxt = ctrl.reflect;
      cnt_nxt     = '0;
      rem_nxt     = '0;
      dsr_nxt     = divisor;
      dvd_nxt     = dividend;
    end else if (busy_r) begin
      cnt_nxt = cnt_r + pcp_pkg::CNT_W'(1);
      if (fix_step) begin
        // Odd pass count in bounce mode: fold the remainder back from the end
        if (reflect_r && quo_r[0]) begin
          if (rem_r == '0) begin
            peak_nxt = 1'b1;
          end else begin
            rem_nxt = dsr_r - rem_r;
          end
        end
      end else begin
        rem_nxt = fits ? diff[pcp_pkg::DUR_W-1:0] : trial[pcp_pkg::DUR_W-1:0];
        dvd_nxt = {dvd_r[pcp_pkg::ELAPSED_BITS-2:0], 1'b0};
        quo_nxt = {quo_r[pcp_pkg::FRACTION_BITS-2:0], fits};
        if (last_step) begin
          busy_nxt = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      peak_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      peak_r <= peak_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    reflect_r <= reflect_nxt;
    rem_r     <= rem_nxt;
    dsr_r     <= dsr_nxt;
    dvd_r     <= dvd_nxt;
    quo_r     <= quo_nxt;
  end

  assign frac      = quo_r;
  assign stat.busy = busy_r;
  assign stat.peak = peak_r;

endmodule

### hw/rtl/playback_clock_progress.sv
// Top level: playback clock run state, elapsed count and serial progress computation.
//
//   channel  | direction | handshake          | payload
//   ---------+-----------+--------------------+---------------------------------------------
//   in_cmd   | in        | valid / ready      | opcode, time_delta
//   out_res  | out       | valid / ready      | playing, paused, progress, run_status
//   cfg_*    | in        | cfg_we (no stall)  | cfg_index, cfg_wdata (play_mode, duration)
//
// An accepted item is launched into the bit-serial divider (elapsed bits, one reflection
// step, fraction bits); its result is loaded into the output register once that is free.
// Commands are taken one at a time; the next one is taken while the previous result
// still waits in the output register.
// Reset is synchronous, active low: stopped, elapsed zero, once mode, 1000-tick duration.
// A stalled result channel holds the finished progress inside the divider until the
// output register frees.
`timescale 1ns / 1ps

module playback_clock_progress (
  input  logic                           clk,
  input  logic                           rst_n,
  pcp_cmd_if.sink                        in_cmd,
  pcp_res_if.source                      out_res,
  input  logic                           cfg_we,
  input  logic [pcp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pcp_pkg::DUR_W-1:0]      cfg_wdata
);

  // Configuration registers
  logic [pcp_pkg::MODE_W-1:0]        mode_r, mode_nxt;
  logic [pcp_pkg::DUR_W-1:0]         dur_r, dur_nxt;

  // Clock state
  pcp_pkg::run_t                     run_r, run_nxt;
  logic [pcp_pkg::ELAPSED_BITS-1:0]  elapsed_r, elapsed_nxt;
  pcp_pkg::fsm_t                     fsm_r, fsm_nxt;

  // Output register
  logic                              out_valid_r, out_valid_nxt;
  logic                              playing_r, playing_nxt;
  logic                              paused_r, paused_nxt;
  logic [pcp_pkg::PROG_W-1:0]        progress_r, progress_nxt;
  logic [pcp_pkg::RUN_W-1:0]         status_r, status_nxt;

  logic                              accept;
  logic                              load;
  logic                              out_free;
  logic [pcp_pkg::DUR_W-1:0]         dur_eff;
  logic                              once_fin;
  logic [pcp_pkg::ELAPSED_BITS:0]    sat_sum;
  logic [pcp_pkg::RES_W-1:0]         prog_sel;
  logic                              playing_now;

  pcp_pkg::div_ctrl_t                div_ctrl;
  pcp_pkg::div_stat_t                div_stat;
  logic [pcp_pkg::FRACTION_BITS-1:0] div_frac;

  pcp_divider u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctrl     (div_ctrl),
    .dividend (elapsed_r),
    .divisor  (dur_eff),
    .frac     (div_frac),
    .stat     (div_stat)
  );

  // A zero duration counts as the one-tick minimum
  always_comb begin
    dur_eff  = (dur_r == '0) ? pcp_pkg::DUR_W'(1) : dur_r;
    once_fin = (pcp_pkg::CMP_W'(elapsed_r) >= pcp_pkg::CMP_W'(dur_eff));
    sat_sum  = (pcp_pkg::ELAPSED_BITS + 1)'(elapsed_r)
             + (pcp_pkg::ELAPSED_BITS + 1)'(in_cmd.time_delta);
  end

  // Next state of the sequencer
  always_comb begin
    fsm_nxt = fsm_r;
    unique case (fsm_r)
      pcp_pkg::FSM_IDLE:   if (in_cmd.valid) fsm_nxt = pcp_pkg::FSM_LAUNCH;
      pcp_pkg::FSM_LAUNCH: fsm_nxt = pcp_pkg::FSM_DIVIDE;
      pcp_pkg::FSM_DIVIDE: if (!div_stat.busy && out_free) fsm_nxt = pcp_pkg::FSM_IDLE;
      default:             fsm_nxt = pcp_pkg::FSM_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    in_cmd.ready     = 1'b0;
    div_ctrl.start   = 1'b0;
    div_ctrl.reflect = (mode_r == pcp_pkg::MODE_BOUNCE);
    load             = 1'b0;
    unique case (fsm_r)
      pcp_pkg::FSM_IDLE:   in_cmd.ready   = 1'b1;
      pcp_pkg::FSM_LAUNCH: div_ctrl.start = 1'b1;
      pcp_pkg::FSM_DIVIDE: load           = !div_stat.busy && out_free;
      default:             load           = 1'b0;
    endcase
  end

  assign accept   = in_cmd.valid && in_cmd.ready;
  assign out_free = !out_valid_r || out_res.ready;

  // Apply the command to the run state and elapsed count
  always_comb begin
    run_nxt     = run_r;
    elapsed_nxt = elapsed_r;
    if (accept) begin
      unique case (pcp_pkg::op_t'(in_cmd.opcode))
        pcp_pkg::OP_TICK: begin
          if (run_r == pcp_pkg::RUN_PLAYING) begin
            // Saturate at the top of the count
            elapsed_nxt = sat_sum[pcp_pkg::ELAPSED_BITS] ? '1
                                                         : sat_sum[pcp_pkg::ELAPSED_BITS-1:0];
          end
        end
        pcp_pkg::OP_PLAY: begin
          if (run_r == pcp_pkg::RUN_STOPPED || (mode_r == pcp_pkg::MODE_ONCE && once_fin)) begin
            elapsed_nxt = '0;
          end
          run_nxt = pcp_pkg::RUN_PLAYING;
        end
        pcp_pkg::OP_PAUSE: begin
          if (run_r == pcp_pkg::RUN_PLAYING) run_nxt = pcp_pkg::RUN_PAUSED;
        end
        pcp_pkg::OP_RESUME: begin
          if (run_r == pcp_pkg::RUN_PAUSED) run_nxt = pcp_pkg::RUN_PLAYING;
        end
        pcp_pkg::OP_STOP: begin
          run_nxt     = pcp_pkg::RUN_STOPPED;
          elapsed_nxt = '0;
        end
        pcp_pkg::OP_RESET: elapsed_nxt = '0;
        default: begin
          run_nxt     = run_r;
          elapsed_nxt = elapsed_r;
        end
      endcase
    end
  end

  // Configuration writes
  always_comb begin
    mode_nxt = mode_r;
    dur_nxt  = dur_r;
    if (cfg_we) begin
      unique case (pcp_pkg::reg_idx_t'(cfg_index))
        pcp_pkg::REG_PLAY_MODE: mode_nxt = cfg_wdata[pcp_pkg::MODE_W-1:0];
        pcp_pkg::REG_DURATION:  dur_nxt  = cfg_wdata;
        default:                dur_nxt  = dur_r;
      endcase
    end
  end

  // Pick the progress value for the current mode
  always_comb begin
    case (mode_r)
      pcp_pkg::MODE_ONCE:   prog_sel = once_fin ? pcp_pkg::ONE_FIX
                                                : pcp_pkg::RES_W'(div_frac);
      pcp_pkg::MODE_LOOP:   prog_sel = pcp_pkg::RES_W'(div_frac);
      pcp_pkg::MODE_BOUNCE: prog_sel = div_stat.peak ? pcp_pkg::ONE_FIX
                                                     : pcp_pkg::RES_W'(div_frac);
      default:              prog_sel = '0;
    endcase
    playing_now = (run_r == pcp_pkg::RUN_PLAYING) &&
                  ((mode_r == pcp_pkg::MODE_LOOP) || (mode_r == pcp_pkg::MODE_BOUNCE) ||
                   !once_fin);
  end

  // Output register: load a finished transaction, drop it once taken
  always_comb begin
    out_valid_nxt = out_valid_r && !out_res.ready;
    playing_nxt   = playing_r;
    paused_nxt    = paused_r;
    progress_nxt  = progress_r;
    status_nxt    = status_r;
    if (load) begin
      out_valid_nxt = 1'b1;
      playing_nxt   = playing_now;
      paused_nxt    = (run_r == pcp_pkg::RUN_PAUSED);
      progress_nxt  = pcp_pkg::PROG_W'(prog_sel);
      status_nxt    = run_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= pcp_pkg::MODE_ONCE;
      dur_r       <= pcp_pkg::DUR_RESET;
      run_r       <= pcp_pkg::RUN_STOPPED;
      elapsed_r   <= '0;
      fsm_r       <= pcp_pkg::FSM_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      mode_r      <= mode_nxt;
      dur_r       <= dur_nxt;
      run_r       <= run_nxt;
      elapsed_r   <= elapsed_nxt;
      fsm_r       <= fsm_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    playing_r  <= playing_nxt;
    paused_r   <= paused_nxt;
    progress_r <= progress_nxt;
    status_r   <= status_nxt;
  end

  assign out_res.valid      = out_valid_r;
  assign out_res.playing    = playing_r;
  assign out_res.paused     = paused_r;
  assign out_res.progress   = progress_r;
  assign out_res.run_status = status_r;

`ifndef SYNTHESIS
  a_elapsed_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !accept |=> $stable(elapsed_r))
    else $error("elapsed count changed without a command");

  a_tick_no_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_cmd.opcode == pcp_pkg::OP_TICK) |=> (elapsed_r >= $past(elapsed_r)))
    else $error("elapsed count wrapped on tick");

  a_stop_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_cmd.opcode == pcp_pkg::OP_STOP)
      |=> (run_r == pcp_pkg::RUN_STOPPED && elapsed_r == '0))
    else $error("stop did not clear the clock");

  a_div_in_divide: assert property (@(posedge clk) disable iff (!rst_n)
    div_stat.busy |-> (fsm_r == pcp_pkg::FSM_DIVIDE))
    else $error("divider busy outside the divide phase");

  a_progress_range: assert property (@(posedge clk) disable iff (!rst_n)
    load |-> (prog_sel <= pcp_pkg::ONE_FIX))
    else $error("progress above one");
`endif

endmodule

### tb/sv/tb_playback_clock_progress.sv
// Testbench: playback clock commands against a cycle-free model of run state and progress.
`timescale 1ns / 1ps

module tb_playback_clock_progress;

  // Opcodes and the mode code that the package leaves without a name.
  localparam logic [pcp_pkg::OP_W-1:0]   OP_SPARE_6 = 3'd6;
  localparam logic [pcp_pkg::OP_W-1:0]   OP_SPARE_7 = 3'd7;
  localparam logic [pcp_pkg::MODE_W-1:0] MODE_SPARE = 2'd3;

  // Settling time after the last status, so nothing is still in flight.
  localparam int SETTLE_CYCLES = 60;
  // Longest quiet stretch allowed: the receiver hold-off plus generous slack.
  localparam int QUIET_LIMIT   = 5000;
  localparam int HOLD_CYCLES   = 400;
  localparam int HOLD_AFTER    = 150;

  typedef struct packed {
    logic [pcp_pkg::OP_W-1:0]    opcode;
    logic [pcp_pkg::DELTA_W-1:0] delta;
  } clock_cmd_t;

  typedef struct packed {
    logic                       playing;
    logic                       paused;
    logic [pcp_pkg::PROG_W-1:0] progress;
    logic [pcp_pkg::RUN_W-1:0]  run_status;
  } clock_status_t;

  logic clk = 1'b0;
  logic rst_n;
  logic                          cfg_we;
  logic [pcp_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [pcp_pkg::DUR_W-1:0]     cfg_wdata;

  pcp_cmd_if cmd ();
  pcp_res_if res ();

  playback_clock_progress dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_cmd    (cmd),
    .out_res   (res),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // 12 ns period.
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Predicted clock: registers and state as they stand after reset.
  logic [pcp_pkg::MODE_W-1:0]       pb_mode     = pcp_pkg::MODE_ONCE;
  logic [pcp_pkg::DUR_W-1:0]        pb_duration = pcp_pkg::DUR_RESET;
  pcp_pkg::run_t                    pb_run      = pcp_pkg::RUN_STOPPED;
  logic [pcp_pkg::ELAPSED_BITS-1:0] pb_elapsed  = '0;

  clock_cmd_t    cmd_backlog[$];
  clock_status_t status_due[$];
  clock_cmd_t    next_cmd;
  clock_status_t got_status;
  clock_status_t want_status;

  int unsigned queued         = 0;
  int unsigned cmds_taken     = 0;
  int unsigned status_checked = 0;
  int unsigned mismatches     = 0;
  int unsigned settings_run   = 0;
  int unsigned send_idle_pct  = 0;
  int unsigned recv_idle_pct  = 0;
  int unsigned hold_left      = 0;
  bit          hold_done      = 1'b0;
  int unsigned quiet_cycles   = 0;

  // Apply one command to the predicted clock and return the status it reports.
  function automatic clock_status_t advance_clock(input logic [pcp_pkg::OP_W-1:0] op,
                                                  input logic [pcp_pkg::DELTA_W-1:0] delta);
    logic [pcp_pkg::ELAPSED_BITS:0] sum;
    logic [63:0]                    dur;
    logic [63:0]                    pos;
    logic [63:0]                    frac;
    clock_status_t                  st;
    // A zero duration behaves as the one-tick minimum.
    dur = (pb_duration == '0) ? 64'd1 : 64'(pb_duration);
    case (op)
      pcp_pkg::OP_TICK: begin
        if (pb_run == pcp_pkg::RUN_PLAYING) begin
          // Saturate rather than wrap the elapsed count.
          sum = {1'b0, pb_elapsed} + (pcp_pkg::ELAPSED_BITS + 1)'(delta);
          pb_elapsed = sum[pcp_pkg::ELAPSED_BITS] ? '1 : sum[pcp_pkg::ELAPSED_BITS-1:0];
        end
      end
      pcp_pkg::OP_PLAY: begin
        // Restart from zero when stopped or when a once-mode run has finished.
        if (pb_run == pcp_pkg::RUN_STOPPED ||
            (pb_mode == pcp_pkg::MODE_ONCE && 64'(pb_elapsed) >= dur))
          pb_elapsed = '0;
        pb_run = pcp_pkg::RUN_PLAYING;
      end
      pcp_pkg::OP_PAUSE: begin
        if (pb_run == pcp_pkg::RUN_PLAYING) pb_run = pcp_pkg::RUN_PAUSED;
      end
      pcp_pkg::OP_RESUME: begin
        if (pb_run == pcp_pkg::RUN_PAUSED) pb_run = pcp_pkg::RUN_PLAYING;
      end
      pcp_pkg::OP_STOP: begin
        pb_run = pcp_pkg::RUN_STOPPED;
        pb_elapsed = '0;
      end
      pcp_pkg::OP_RESET: pb_elapsed = '0;
      default: ;
    endcase

    if (pb_mode == pcp_pkg::MODE_ONCE) begin
      frac = (64'(pb_elapsed) >= dur) ? 64'(pcp_pkg::ONE_FIX)
                                      : ((64'(pb_elapsed) << pcp_pkg::FRACTION_BITS) / dur);
    end else if (pb_mode == pcp_pkg::MODE_LOOP) begin
      pos = 64'(pb_elapsed) % dur;
      frac = (pos << pcp_pkg::FRACTION_BITS) / dur;
    end else if (pb_mode == pcp_pkg::MODE_BOUNCE) begin
      // Fold the second half of each double pass back towards zero.
      pos = 64'(pb_elapsed) % (dur << 1);
      if (pos > dur) pos = (dur << 1) - pos;
      frac = (pos << pcp_pkg::FRACTION_BITS) / dur;
    end else begin
      frac = '0;
    end

    st.playing    = (pb_run == pcp_pkg::RUN_PLAYING) &&
                    (pb_mode == pcp_pkg::MODE_LOOP || pb_mode == pcp_pkg::MODE_BOUNCE ||
                     64'(pb_elapsed) < dur);
    st.paused     = (pb_run == pcp_pkg::RUN_PAUSED);
    st.progress   = frac[pcp_pkg::PROG_W-1:0];
    st.run_status = pb_run;
    return st;
  endfunction

  function automatic void queue_cmd(input logic [pcp_pkg::OP_W-1:0] op,
                                    input logic [pcp_pkg::DELTA_W-1:0] delta);
    cmd_backlog.push_back({op, delta});
    queued++;
  endfunction

  // Tick sizes: random, tiny, scaled to the duration (so progress sweeps the range) or extreme.
  function automatic logic [pcp_pkg::DELTA_W-1:0] pick_delta(input int unsigned dur);
    int unsigned span;
    span = (dur > 65535) ? 65535 : ((dur == 0) ? 1 : dur);
    case ($urandom_range(4))
      0: return pcp_pkg::DELTA_W'($urandom);
      1: return pcp_pkg::DELTA_W'($urandom_range(0, 3));
      2: return pcp_pkg::DELTA_W'($urandom_range(0, span));
      3: return pcp_pkg::DELTA_W'($urandom_range(0, span / 4 + 1));
      default: return $urandom_range(1) ? {pcp_pkg::DELTA_W{1'b1}} : {pcp_pkg::DELTA_W{1'b0}};
    endcase
  endfunction

  // One playback scene: play, a run of ticks with the odd pause, restart or
  // rewind, and sometimes a stop. Now and then queue plain noise instead.
  function automatic void queue_scene(input int unsigned dur);
    int unsigned n;
    int unsigned pick;
    if ($urandom_range(99) < 15) begin
      n = $urandom_range(1, 4);
      repeat (n) queue_cmd(pcp_pkg::OP_W'($urandom_range(7)), pcp_pkg::DELTA_W'($urandom));
      return;
    end
    queue_cmd(pcp_pkg::OP_PLAY, pcp_pkg::DELTA_W'($urandom));
    n = $urandom_range(2, 12);
    repeat (n) begin
      pick = $urandom_range(99);
      if (pick < 8) begin
        queue_cmd(pcp_pkg::OP_PAUSE, pcp_pkg::DELTA_W'($urandom));
        queue_cmd(pcp_pkg::OP_TICK, pick_delta(dur));
        queue_cmd(pcp_pkg::OP_RESUME, pcp_pkg::DELTA_W'($urandom));
      end else if (pick < 12) begin
        queue_cmd(pcp_pkg::OP_RESET, pcp_pkg::DELTA_W'($urandom));
      end else if (pick < 16) begin
        queue_cmd(pcp_pkg::OP_PLAY, pcp_pkg::DELTA_W'($urandom));
      end else begin
        queue_cmd(pcp_pkg::OP_TICK, pick_delta(dur));
      end
    end
    if ($urandom_range(99) < 40) queue_cmd(pcp_pkg::OP_STOP, pcp_pkg::DELTA_W'($urandom));
  endfunction

  // Hold until every queued command is taken and every status has come back,
  // then let the divider run out.
  task automatic settle();
    while (cmd_backlog.size() != 0 || cmd.valid || status_due.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input pcp_pkg::reg_idx_t idx,
                           input logic [pcp_pkg::DUR_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
    // The block is idle here, so update the predicted registers at once.
    if (idx == pcp_pkg::REG_PLAY_MODE) pb_mode = val[pcp_pkg::MODE_W-1:0];
    else pb_duration = val;
  endtask

  // Reprogram both registers with the block idle, then queue random scenes.
  task automatic run_setting(input logic [pcp_pkg::DUR_W-1:0] mode_word,
                             input logic [pcp_pkg::DUR_W-1:0] dur_word,
                             input int unsigned count, input int unsigned send_idle,
                             input int unsigned recv_idle);
    int unsigned target;
    settle();
    send_idle_pct = send_idle;
    recv_idle_pct = recv_idle;
    write_reg(pcp_pkg::REG_PLAY_MODE, mode_word);
    write_reg(pcp_pkg::REG_DURATION, dur_word);
    settings_run++;
    target = queued + count;
    while (queued < target) queue_scene(dur_word);
  endtask

  // Driver: offer the next queued command whenever the slot is free, idling at
  // random; predict the status of each command at the edge that takes it.
  always @(posedge clk) begin
    if (!rst_n) begin
      cmd.valid <= 1'b0;
    end else begin
      if (cmd.valid && cmd.ready) begin
        status_due.push_back(advance_clock(cmd.opcode, cmd.time_delta));
        cmds_taken++;
      end
      if (!cmd.valid || cmd.ready) begin
        if (cmd_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          next_cmd = cmd_backlog.pop_front();
          cmd.valid      <= 1'b1;
          cmd.opcode     <= next_cmd.opcode;
          cmd.time_delta <= next_cmd.delta;
        end else begin
          cmd.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each status transaction against the oldest prediction and
  // drive ready, with one long hold-off so that the block backs up.
  always @(posedge clk) begin
    if (!rst_n) begin
      res.ready <= 1'b0;
    end else begin
      if (res.valid && res.ready) begin
        got_status = {res.playing, res.paused, res.progress, res.run_status};
        if (status_due.size() == 0) begin
          $display("%0t: status with nothing predicted: playing=%0d paused=%0d %s",
                   $time, got_status.playing, got_status.paused,
                   $sformatf("progress=%0d run=%0d", got_status.progress,
                             got_status.run_status));
          mismatches++;
        end else begin
          want_status = status_due.pop_front();
          if (got_status !== want_status) begin
            $display("%0t: status mismatch, expected playing=%0d paused=%0d %s",
                     $time, want_status.playing, want_status.paused,
                     $sformatf("progress=%0d run=%0d", want_status.progress,
                               want_status.run_status));
            $display("%0t:                  actual playing=%0d paused=%0d %s",
                     $time, got_status.playing, got_status.paused,
                     $sformatf("progress=%0d run=%0d", got_status.progress,
                               got_status.run_status));
            mismatches++;
          end
        end
        status_checked++;
      end
      if (hold_left != 0) begin
        hold_left--;
        res.ready <= 1'b0;
      end else if (!hold_done && status_checked >= HOLD_AFTER) begin
        // Drop ready for a long stretch while the sender keeps offering.
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
        res.ready <= 1'b0;
      end else begin
        res.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Watchdog: end the run if no transaction moves on either channel for too long.
  always @(posedge clk) begin
    if (!rst_n || (cmd.valid && cmd.ready) || (res.valid && res.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("timeout: no transaction for %0d cycles", QUIET_LIMIT);
      $display("tb: failure");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst_n          = 1'b0;
    cfg_we         = 1'b0;
    cfg_index      = pcp_pkg::REG_PLAY_MODE;
    cfg_wdata      = '0;
    cmd.valid      = 1'b0;
    cmd.opcode     = pcp_pkg::OP_TICK;
    cmd.time_delta = '0;
    res.ready      = 1'b0;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Directed run at the reset settings (once mode, 1000 ticks).
    send_idle_pct = 20;
    recv_idle_pct = 47;
    queue_cmd(pcp_pkg::OP_TICK, 16'hFFFF);     // tick while stopped: no effect
    queue_cmd(pcp_pkg::OP_PAUSE, 16'h0000);    // pause while stopped: ignored
    queue_cmd(pcp_pkg::OP_RESUME, 16'h0000);   // resume while stopped: ignored
    queue_cmd(pcp_pkg::OP_PLAY, 16'h0000);
    queue_cmd(pcp_pkg::OP_TICK, 16'd0);
    queue_cmd(pcp_pkg::OP_TICK, 16'd999);
    queue_cmd(pcp_pkg::OP_PAUSE, 16'h0000);
    queue_cmd(pcp_pkg::OP_TICK, 16'd500);      // paused: elapsed holds
    queue_cmd(pcp_pkg::OP_PAUSE, 16'h0000);    // already paused: ignored
    queue_cmd(pcp_pkg::OP_RESUME, 16'h0000);
    queue_cmd(pcp_pkg::OP_RESUME, 16'h0000);   // already playing: ignored
    queue_cmd(pcp_pkg::OP_TICK, 16'd1);        // reaches the duration exactly: finished
    queue_cmd(pcp_pkg::OP_TICK, 16'hFFFF);     // past the end: progress stays clamped
    queue_cmd(pcp_pkg::OP_PLAY, 16'h0000);     // finished once run: restart from zero
    queue_cmd(pcp_pkg::OP_TICK, 16'd250);
    queue_cmd(pcp_pkg::OP_PLAY, 16'h0000);     // mid-run play: carry on
    queue_cmd(pcp_pkg::OP_RESET, 16'h0000);
    queue_cmd(OP_SPARE_6, 16'h5555);           // unused opcodes change nothing
    queue_cmd(OP_SPARE_7, 16'hAAAA);
    queue_cmd(pcp_pkg::OP_TICK, 16'hAAAA);
    queue_cmd(pcp_pkg::OP_STOP, 16'h0000);
    queue_cmd(pcp_pkg::OP_TICK, 16'h5555);
    queue_cmd(pcp_pkg::OP_PLAY, 16'hFFFF);
    queue_cmd(pcp_pkg::OP_STOP, 16'hFFFF);

    // Sender idles lightly, receiver heavily.
    run_setting(pcp_pkg::DUR_W'(pcp_pkg::MODE_ONCE),   24'd1, 112, 20, 47);
    run_setting(pcp_pkg::DUR_W'(pcp_pkg::MODE_LOOP),   24'd7, 112, 20, 47);
    run_setting(pcp_pkg::DUR_W'(pcp_pkg::MODE_BOUNCE), 24'd5, 112, 20, 47);
    // Roles swapped; the spare mode is written with noise in the upper bits.
    run_setting({(pcp_pkg::DUR_W - pcp_pkg::MODE_W)'($urandom), MODE_SPARE}, 24'd40,
                112, 47, 20);
    run_setting(pcp_pkg::DUR_W'(pcp_pkg::MODE_LOOP),   24'd0,      112, 47, 20);
    run_setting(pcp_pkg::DUR_W'(pcp_pkg::MODE_BOUNCE), 24'hFFFFFF, 112, 47, 20);
    // No idling on either side.
    run_setting(pcp_pkg::DUR_W'(pcp_pkg::MODE_LOOP),
                pcp_pkg::DUR_W'($urandom_range(1000, 200000)), 112, 0, 0);
    run_setting(pcp_pkg::DUR_W'(pcp_pkg::MODE_BOUNCE),
                pcp_pkg::DUR_W'($urandom_range(1, 300)), 112, 0, 0);
    run_setting(pcp_pkg::DUR_W'(pcp_pkg::MODE_ONCE),
                pcp_pkg::DUR_W'($urandom_range(50, 5000)), 112, 0, 0);
    settle();

    $display("summary: %0d commands over %0d register settings (once, loop, bounce, spare mode;",
             cmds_taken, settings_run);
    $display("summary: durations 0 to max), %0d statuses checked, %0d mismatches",
             status_checked, mismatches);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

### filelist.f
hw/rtl/pcp_pkg.sv
hw/rtl/pcp_if.sv
hw/rtl/pcp_divider.sv
hw/rtl/playback_clock_progress.sv
tb/sv/tb_playback_clock_progress.sv
